[sv/assert_macros.svh]
// Assertion macros shared by the bounding box RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on clk_i, off while rst_ni is low.
`define VPBB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on clk_i at every edge, reset included.
`define VPBB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[sv/vpbb_pkg.sv]
// Types and constants shared by the voxel placement bounding box modules.
package vpbb_pkg;

  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned SizeW  = 13;
  localparam int unsigned LocW   = 12;
  localparam int unsigned OrgW   = 31;
  localparam int unsigned CoordW = 32;

  typedef enum logic [2:0] {
    RegSizeX   = 3'd0,
    RegSizeZ   = 3'd1,
    RegMirror  = 3'd2,
    RegRot     = 3'd3,
    RegOriginX = 3'd4,
    RegOriginY = 3'd5,
    RegOriginZ = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    MirrorNone = 2'd0,
    MirrorX    = 2'd1,
    MirrorZ    = 2'd2
  } mirror_e;

  typedef enum logic [1:0] {
    RotNone  = 2'd0,
    RotCw90  = 2'd1,
    Rot180   = 2'd2,
    RotCcw90 = 2'd3
  } rot_e;

  typedef struct packed {
    logic        [SizeW-1:0] size_x;
    logic        [SizeW-1:0] size_z;
    logic        [1:0]       mirror_mode;
    logic        [1:0]       rotation;
    logic signed [OrgW-1:0]  origin_x;
    logic signed [OrgW-1:0]  origin_y;
    logic signed [OrgW-1:0]  origin_z;
  } cfg_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic                     count;
    logic                     last;
  } pt_t;

endpackage

[sv/vpbb_regs.sv]
// Configuration register file behind the APB-style port.
module vpbb_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [vpbb_pkg::AddrW-1:0] paddr,
  input  logic [vpbb_pkg::DataW-1:0] pwdata,
  output logic [vpbb_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output vpbb_pkg::cfg_t             cfg_o
);
  import vpbb_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size_x      <= SizeW'(1);
      cfg_q.size_z      <= SizeW'(1);
      cfg_q.mirror_mode <= MirrorNone;
      cfg_q.rotation    <= RotNone;
      cfg_q.origin_x    <= '0;
      cfg_q.origin_y    <= '0;
      cfg_q.origin_z    <= '0;
    end else if (wr_en) begin
      case (idx)
        RegSizeX:   cfg_q.size_x      <= pwdata[SizeW-1:0];
        RegSizeZ:   cfg_q.size_z      <= pwdata[SizeW-1:0];
        RegMirror:  cfg_q.mirror_mode <= pwdata[1:0];
        RegRot:     cfg_q.rotation    <= pwdata[1:0];
        RegOriginX: cfg_q.origin_x    <= pwdata[OrgW-1:0];
        RegOriginY: cfg_q.origin_y    <= pwdata[OrgW-1:0];
        RegOriginZ: cfg_q.origin_z    <= pwdata[OrgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegSizeX:   prdata = {{(DataW-SizeW){1'b0}}, cfg_q.size_x};
      RegSizeZ:   prdata = {{(DataW-SizeW){1'b0}}, cfg_q.size_z};
      RegMirror:  prdata = {{(DataW-2){1'b0}}, cfg_q.mirror_mode};
      RegRot:     prdata = {{(DataW-2){1'b0}}, cfg_q.rotation};
      RegOriginX: prdata = {cfg_q.origin_x[OrgW-1], cfg_q.origin_x};
      RegOriginY: prdata = {cfg_q.origin_y[OrgW-1], cfg_q.origin_y};
      RegOriginZ: prdata = {cfg_q.origin_z[OrgW-1], cfg_q.origin_z};
      default:    prdata = '0;
    endcase
  end

endmodule

[sv/vpbb_xform.sv]
// Input register and local-to-world transform feeding the point register.
module vpbb_xform #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  vpbb_pkg::cfg_t                   cfg_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             item_kind_i,
  input  logic        [vpbb_pkg::LocW-1:0] local_x_i,
  input  logic        [vpbb_pkg::LocW-1:0] local_y_i,
  input  logic        [vpbb_pkg::LocW-1:0] local_z_i,
  input  logic signed [vpbb_pkg::OrgW-1:0] world_x_i,
  input  logic signed [vpbb_pkg::OrgW-1:0] world_y_i,
  input  logic signed [vpbb_pkg::OrgW-1:0] world_z_i,
  input  logic                             skip_i,
  input  logic                             last_i,
  output logic                             pt_valid_o,
  input  logic                             pt_ready_i,
  output vpbb_pkg::pt_t                    pt_o
);
  import vpbb_pkg::*;

  // 17 bits hold the largest allowed MAX_DIM; local math stays in 16 signed bits.
  localparam int unsigned DimW = 17;
  localparam int unsigned LclW = 16;
  localparam logic [DimW-1:0] MaxDim = DimW'(MAX_DIM);

  // Input register
  logic                    a_valid_q;
  logic                    a_kind_q;
  logic        [LocW-1:0]  a_lx_q, a_ly_q, a_lz_q;
  logic signed [OrgW-1:0]  a_wx_q, a_wy_q, a_wz_q;
  logic                    a_skip_q, a_last_q;

  // Point register
  logic b_valid_q;
  pt_t  pt_q, pt_d;
  logic a_ready, b_ready;

  logic        [SizeW-1:0] sx, sz;
  logic signed [LclW-1:0]  sxm1, szm1, lx, ly, lz, xm, zm, rx, rz;

  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] s);
    logic [SizeW-1:0] r;
    if (s == '0) begin
      r = SizeW'(1);
    end else if ({{(DimW-SizeW){1'b0}}, s} > MaxDim) begin
      r = MaxDim[SizeW-1:0];
    end else begin
      r = s;
    end
    return r;
  endfunction

  assign b_ready    = !b_valid_q || pt_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;
  assign pt_valid_o = b_valid_q;
  assign pt_o       = pt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && a_ready) begin
      a_kind_q <= item_kind_i;
      a_lx_q   <= local_x_i;
      a_ly_q   <= local_y_i;
      a_lz_q   <= local_z_i;
      a_wx_q   <= world_x_i;
      a_wy_q   <= world_y_i;
      a_wz_q   <= world_z_i;
      a_skip_q <= skip_i;
      a_last_q <= last_i;
    end
    if (b_ready && a_valid_q) begin
      pt_q <= pt_d;
    end
  end

  always_comb begin
    sx   = clamp_size(cfg_i.size_x);
    sz   = clamp_size(cfg_i.size_z);
    sxm1 = $signed({{(LclW-SizeW){1'b0}}, sx}) - 16'sd1;
    szm1 = $signed({{(LclW-SizeW){1'b0}}, sz}) - 16'sd1;
    lx   = $signed({{(LclW-LocW){1'b0}}, a_lx_q});
    ly   = $signed({{(LclW-LocW){1'b0}}, a_ly_q});
    lz   = $signed({{(LclW-LocW){1'b0}}, a_lz_q});

    xm = lx;
    zm = lz;
    case (mirror_e'(cfg_i.mirror_mode))
      MirrorX: xm = sxm1 - lx;
      MirrorZ: zm = szm1 - lz;
      default: ;
    endcase

    case (rot_e'(cfg_i.rotation))
      RotCw90: begin
        rx = szm1 - zm;
        rz = xm;
      end
      Rot180: begin
        rx = sxm1 - xm;
        rz = szm1 - zm;
      end
      RotCcw90: begin
        rx = zm;
        rz = sxm1 - xm;
      end
      default: begin
        rx = xm;
        rz = zm;
      end
    endcase

    if (a_kind_q) begin
      pt_d.x = {a_wx_q[OrgW-1], a_wx_q};
      pt_d.y = {a_wy_q[OrgW-1], a_wy_q};
      pt_d.z = {a_wz_q[OrgW-1], a_wz_q};
    end else begin
      pt_d.x = {cfg_i.origin_x[OrgW-1], cfg_i.origin_x}
             + {{(CoordW-LclW){rx[LclW-1]}}, rx};
      pt_d.y = {cfg_i.origin_y[OrgW-1], cfg_i.origin_y}
             + {{(CoordW-LclW){ly[LclW-1]}}, ly};
      pt_d.z = {cfg_i.origin_z[OrgW-1], cfg_i.origin_z}
             + {{(CoordW-LclW){rz[LclW-1]}}, rz};
    end
    pt_d.count = !a_skip_q;
    pt_d.last  = a_last_q;
  end

endmodule

[sv/vpbb_accum.sv]
// Running min/max per axis and the box result register.
module vpbb_accum (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  vpbb_pkg::cfg_t                     cfg_i,
  input  logic                               pt_valid_i,
  output logic                               pt_ready_o,
  input  vpbb_pkg::pt_t                      pt_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [vpbb_pkg::CoordW-1:0] box_min_x_o,
  output logic signed [vpbb_pkg::CoordW-1:0] box_min_y_o,
  output logic signed [vpbb_pkg::CoordW-1:0] box_min_z_o,
  output logic signed [vpbb_pkg::CoordW-1:0] box_max_x_o,
  output logic signed [vpbb_pkg::CoordW-1:0] box_max_y_o,
  output logic signed [vpbb_pkg::CoordW-1:0] box_max_z_o,
  output logic                               box_empty_o
);
  import vpbb_pkg::*;
  `include "assert_macros.svh"

  logic signed [CoordW-1:0] min_x_q, min_y_q, min_z_q, max_x_q, max_y_q, max_z_q;
  logic signed [CoordW-1:0] min_x_d, min_y_d, min_z_d, max_x_d, max_y_d, max_z_d;
  logic                     any_q, any_d;
  logic                     out_valid_q;
  logic                     take;
  logic signed [CoordW-1:0] org_x, org_y, org_z;
  logic                     box_flat, box_ordered, seed_beat;

  assign pt_ready_o  = !out_valid_q || out_ready_i;
  assign take        = pt_valid_i && pt_ready_o;
  assign out_valid_o = out_valid_q;
  assign org_x       = {cfg_i.origin_x[OrgW-1], cfg_i.origin_x};
  assign org_y       = {cfg_i.origin_y[OrgW-1], cfg_i.origin_y};
  assign org_z       = {cfg_i.origin_z[OrgW-1], cfg_i.origin_z};

  // Fold the incoming point into the running box; the first counted point seeds it.
  always_comb begin
    min_x_d = min_x_q;
    min_y_d = min_y_q;
    min_z_d = min_z_q;
    max_x_d = max_x_q;
    max_y_d = max_y_q;
    max_z_d = max_z_q;
    any_d   = any_q || pt_i.count;
    if (pt_i.count) begin
      if (!any_q || pt_i.x < min_x_q) min_x_d = pt_i.x;
      if (!any_q || pt_i.y < min_y_q) min_y_d = pt_i.y;
      if (!any_q || pt_i.z < min_z_q) min_z_d = pt_i.z;
      if (!any_q || pt_i.x > max_x_q) max_x_d = pt_i.x;
      if (!any_q || pt_i.y > max_y_q) max_y_d = pt_i.y;
      if (!any_q || pt_i.z > max_z_q) max_z_d = pt_i.z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take && pt_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (take) begin
        any_q <= pt_i.last ? 1'b0 : any_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      min_x_q <= min_x_d;
      min_y_q <= min_y_d;
      min_z_q <= min_z_d;
      max_x_q <= max_x_d;
      max_y_q <= max_y_d;
      max_z_q <= max_z_d;
      if (pt_i.last) begin
        box_min_x_o <= any_d ? min_x_d : org_x;
        box_min_y_o <= any_d ? min_y_d : org_y;
        box_min_z_o <= any_d ? min_z_d : org_z;
        box_max_x_o <= any_d ? max_x_d : org_x;
        box_max_y_o <= any_d ? max_y_d : org_y;
        box_max_z_o <= any_d ? max_z_d : org_z;
        box_empty_o <= !any_d;
      end
    end
  end

  assign box_flat    = box_min_x_o == box_max_x_o && box_min_y_o == box_max_y_o
                    && box_min_z_o == box_max_z_o;
  assign box_ordered = box_min_x_o <= box_max_x_o && box_min_y_o <= box_max_y_o
                    && box_min_z_o <= box_max_z_o;
  assign seed_beat   = take && pt_i.count && !pt_i.last;

  `VPBB_ASSERT(a_empty_box_flat, out_valid_q && box_empty_o |-> box_flat, "empty box min != max")
  `VPBB_ASSERT(a_box_ordered, out_valid_q && !box_empty_o |-> box_ordered, "box min above max")
  `VPBB_ASSERT(a_run_clears, take && pt_i.last |=> !any_q, "run state not cleared after last beat")
  `VPBB_ASSERT(a_any_source, $rose(any_q) |-> $past(seed_beat), "run counted without a beat")

endmodule

[sv/voxel_placement_bounding_box.sv]
// Top level of the voxel placement bounding box block.
// Streams voxel items and returns the axis-aligned bounding box of their
// world positions. A local item (item_kind 0) is mirrored within size_x /
// size_z, rotated and offset by the origin; an override item (item_kind 1)
// carries its world position directly; items with skip set are not counted.
// The item flagged last closes the run: one result beat carries the box,
// with box_empty set and min = max = origin when nothing was counted, and
// the run state clears. Throughput is one item per clock; the last item passes
// through the input register, then the point register, and out_valid_o rises
// when the result register loads the box. Backpressure from out_ready_i
// reaches in_ready_o combinationally through each stage's ready logic; the
// stream stalls only while a box beat waits with out_ready_i low.
// Configuration registers sit at byte offsets 4*i of the APB-style port and
// should only be written while no item is in flight.
module voxel_placement_bounding_box #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [vpbb_pkg::AddrW-1:0]         paddr,
  input  logic [vpbb_pkg::DataW-1:0]         pwdata,
  output logic [vpbb_pkg::DataW-1:0]         prdata,
  output logic                               pready,
  // Item channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               item_kind_i,
  input  logic        [vpbb_pkg::LocW-1:0]   local_x_i,
  input  logic        [vpbb_pkg::LocW-1:0]   local_y_i,
  input  logic        [vpbb_pkg::LocW-1:0]   local_z_i,
  input  logic signed [vpbb_pkg::OrgW-1:0]   world_x_i,
  input  logic signed [vpbb_pkg::OrgW-1:0]   world_y_i,
  input  logic signed [vpbb_pkg::OrgW-1:0]   world_z_i,
  input  logic                               skip_i,
  input  logic                               last_i,
  // Box channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [vpbb_pkg::CoordW-1:0] box_min_x_o,
  output logic signed [vpbb_pkg::CoordW-1:0] box_min_y_o,
  output logic signed [vpbb_pkg::CoordW-1:0] box_min_z_o,
  output logic signed [vpbb_pkg::CoordW-1:0] box_max_x_o,
  output logic signed [vpbb_pkg::CoordW-1:0] box_max_y_o,
  output logic signed [vpbb_pkg::CoordW-1:0] box_max_z_o,
  output logic                               box_empty_o
);
  import vpbb_pkg::*;

  cfg_t cfg;     // live configuration; the user must keep it stable while items flow, the block does not enforce it
  pt_t  pt;      // transformed world point with count/last flags
  logic pt_valid;
  logic pt_ready;

  // Hold the configuration registers.
  vpbb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Register each item beat, map it to world space, register the point.
  vpbb_xform #(
    .MAX_DIM (MAX_DIM)
  ) u_xform (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .item_kind_i (item_kind_i),
    .local_x_i   (local_x_i),
    .local_y_i   (local_y_i),
    .local_z_i   (local_z_i),
    .world_x_i   (world_x_i),
    .world_y_i   (world_y_i),
    .world_z_i   (world_z_i),
    .skip_i      (skip_i),
    .last_i      (last_i),
    .pt_valid_o  (pt_valid),
    .pt_ready_i  (pt_ready),
    .pt_o        (pt)
  );

  // Advance the running box and emit it on the last beat of a run.
  vpbb_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pt_valid_i  (pt_valid),
    .pt_ready_o  (pt_ready),
    .pt_i        (pt),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .box_min_x_o (box_min_x_o),
    .box_min_y_o (box_min_y_o),
    .box_min_z_o (box_min_z_o),
    .box_max_x_o (box_max_x_o),
    .box_max_y_o (box_max_y_o),
    .box_max_z_o (box_max_z_o),
    .box_empty_o (box_empty_o)
  );

endmodule

[test/tb.sv]
// Self-checking bench for the voxel placement bounding box, with a local box model.
module tb;
  import vpbb_pkg::*;

  localparam int MaxDim = 4096;
  localparam int IdlePct = 12;
  localparam int SettleCycles = 8;
  localparam int VoxelTarget = 1300;
  localparam int VoxelsPerSetting = 60;
  localparam logic [SizeW-1:0] SizeTop = '1;
  localparam logic [LocW-1:0] LocMax = '1;
  localparam logic signed [OrgW-1:0] OrgMin = {1'b1, {(OrgW-1){1'b0}}};
  localparam logic signed [OrgW-1:0] OrgMax = {1'b0, {(OrgW-1){1'b1}}};
  // Mirror code with no meaning of its own; the block must treat it as no mirror.
  localparam logic [1:0] MirrorSpare = 2'd3;

  typedef struct packed {
    logic                    kind;
    logic        [LocW-1:0]  lx, ly, lz;
    logic signed [OrgW-1:0]  wx, wy, wz;
    logic                    skip;
    logic                    last;
  } voxel_t;

  typedef struct packed {
    logic signed [CoordW-1:0] min_x, min_y, min_z;
    logic signed [CoordW-1:0] max_x, max_y, max_z;
    logic                     empty;
  } box_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata, prdata;
  logic pready;
  logic in_valid_i, in_ready_o;
  logic item_kind_i;
  logic [LocW-1:0] local_x_i, local_y_i, local_z_i;
  logic signed [OrgW-1:0] world_x_i, world_y_i, world_z_i;
  logic skip_i, last_i;
  logic out_valid_o, out_ready_i;
  logic signed [CoordW-1:0] box_min_x_o, box_min_y_o, box_min_z_o;
  logic signed [CoordW-1:0] box_max_x_o, box_max_y_o, box_max_z_o;
  logic box_empty_o;

  // Placement settings as the block should hold them after each register write.
  logic [SizeW-1:0] size_x_q, size_z_q;
  logic [1:0] mirror_q, rot_q;
  logic signed [OrgW-1:0] org_x_q, org_y_q, org_z_q;

  // Running box of the open run, and the boxes still owed by the block.
  box_t run_box;
  logic run_any;
  box_t expected_boxes[$];
  voxel_t pending_voxels[$];

  bit in_beat;   // set at the rising edge when an item beat was taken
  bit steady;    // suppress all idling on both sides
  int pushed, accepted, counted, skipped, runs_closed, boxes_seen, settings, mismatches;

  voxel_placement_bounding_box #(.MAX_DIM(MaxDim)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_kind_i(item_kind_i),
    .local_x_i  (local_x_i),
    .local_y_i  (local_y_i),
    .local_z_i  (local_z_i),
    .world_x_i  (world_x_i),
    .world_y_i  (world_y_i),
    .world_z_i  (world_z_i),
    .skip_i     (skip_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .box_min_x_o(box_min_x_o),
    .box_min_y_o(box_min_y_o),
    .box_min_z_o(box_min_z_o),
    .box_max_x_o(box_max_x_o),
    .box_max_y_o(box_max_y_o),
    .box_max_z_o(box_max_z_o),
    .box_empty_o(box_empty_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs a handshake.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Out-of-range sizes fold into 1..MaxDim before any mirror or rotation.
  function automatic int extent(input logic [SizeW-1:0] s);
    if (s == '0) return 1;
    if (s > MaxDim) return MaxDim;
    return int'(s);
  endfunction

  // World position of one voxel under the current placement.
  function automatic void place_voxel(input voxel_t v, output int px, output int py,
                                      output int pz);
    int sx, sz, x, z, rx, rz;
    if (v.kind) begin
      px = $signed(v.wx);
      py = $signed(v.wy);
      pz = $signed(v.wz);
    end else begin
      sx = extent(size_x_q);
      sz = extent(size_z_q);
      x = int'(v.lx);
      z = int'(v.lz);
      case (mirror_q)
        MirrorX: x = sx - 1 - x;
        MirrorZ: z = sz - 1 - z;
        default: ;
      endcase
      case (rot_q)
        RotCw90: begin
          rx = sz - 1 - z;
          rz = x;
        end
        Rot180: begin
          rx = sx - 1 - x;
          rz = sz - 1 - z;
        end
        RotCcw90: begin
          rx = z;
          rz = sx - 1 - x;
        end
        default: begin
          rx = x;
          rz = z;
        end
      endcase
      px = $signed(org_x_q) + rx;
      py = $signed(org_y_q) + int'(v.ly);
      pz = $signed(org_z_q) + rz;
    end
  endfunction

  task automatic check_field(input string name, input logic [CoordW-1:0] want,
                             input logic [CoordW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  // Item driver: present the next pending voxel once the current beat is gone,
  // idling at random unless the steady window is open. Stall the box side too.
  always @(negedge clk_i) begin
    voxel_t v;
    if (!in_valid_i || in_beat) begin
      if (pending_voxels.size() != 0 && (steady || $urandom_range(99) >= IdlePct)) begin
        v = pending_voxels.pop_front();
        in_valid_i  <= 1'b1;
        item_kind_i <= v.kind;
        local_x_i   <= v.lx;
        local_y_i   <= v.ly;
        local_z_i   <= v.lz;
        world_x_i   <= v.wx;
        world_y_i   <= v.wy;
        world_z_i   <= v.wz;
        skip_i      <= v.skip;
        last_i      <= v.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= steady || ($urandom_range(99) >= IdlePct);
  end

  // Monitor: fold each accepted voxel into the running box, close the run on
  // last, and compare every box beat with the oldest owed box.
  always @(posedge clk_i) begin
    voxel_t v;
    box_t want, got;
    int px, py, pz;
    in_beat = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        in_beat = 1'b1;
        accepted++;
        v = {item_kind_i, local_x_i, local_y_i, local_z_i, world_x_i, world_y_i,
             world_z_i, skip_i, last_i};
        if (!v.skip) begin
          place_voxel(v, px, py, pz);
          if (!run_any) begin
            run_box.min_x = px;
            run_box.min_y = py;
            run_box.min_z = pz;
            run_box.max_x = px;
            run_box.max_y = py;
            run_box.max_z = pz;
            run_any = 1'b1;
          end else begin
            if (px < run_box.min_x) run_box.min_x = px;
            if (py < run_box.min_y) run_box.min_y = py;
            if (pz < run_box.min_z) run_box.min_z = pz;
            if (px > run_box.max_x) run_box.max_x = px;
            if (py > run_box.max_y) run_box.max_y = py;
            if (pz > run_box.max_z) run_box.max_z = pz;
          end
        end
        if (v.last) begin
          if (run_any) begin
            want = run_box;
            want.empty = 1'b0;
          end else begin
            // Nothing counted: the box collapses onto the origin.
            want.min_x = $signed(org_x_q);
            want.min_y = $signed(org_y_q);
            want.min_z = $signed(org_z_q);
            want.max_x = $signed(org_x_q);
            want.max_y = $signed(org_y_q);
            want.max_z = $signed(org_z_q);
            want.empty = 1'b1;
          end
          expected_boxes.push_back(want);
          run_any = 1'b0;
          run_box = '0;
          runs_closed++;
        end
      end
      if (out_valid_o && out_ready_i) begin
        boxes_seen++;
        if (expected_boxes.size() == 0) begin
          $error("box beat with no run closed");
          mismatches++;
        end else begin
          want = expected_boxes.pop_front();
          got = {box_min_x_o, box_min_y_o, box_min_z_o, box_max_x_o, box_max_y_o,
                 box_max_z_o, box_empty_o};
          check_field("box_min_x", want.min_x, got.min_x);
          check_field("box_min_y", want.min_y, got.min_y);
          check_field("box_min_z", want.min_z, got.min_z);
          check_field("box_max_x", want.max_x, got.max_x);
          check_field("box_max_y", want.max_y, got.max_y);
          check_field("box_max_z", want.max_z, got.max_z);
          check_field("box_empty", CoordW'(want.empty), CoordW'(got.empty));
        end
      end
    end
  end

  // One register write: setup cycle, then access cycle; pready is always high.
  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegSizeX:   size_x_q = data[SizeW-1:0];
      RegSizeZ:   size_z_q = data[SizeW-1:0];
      RegMirror:  mirror_q = data[1:0];
      RegRot:     rot_q    = data[1:0];
      RegOriginX: org_x_q  = data[OrgW-1:0];
      RegOriginY: org_y_q  = data[OrgW-1:0];
      RegOriginZ: org_z_q  = data[OrgW-1:0];
      default: ;
    endcase
  endtask

  task automatic place(input logic [SizeW-1:0] sx, input logic [SizeW-1:0] sz,
                       input logic [1:0] mir, input logic [1:0] rot,
                       input logic signed [OrgW-1:0] ox, input logic signed [OrgW-1:0] oy,
                       input logic signed [OrgW-1:0] oz);
    write_reg(RegSizeX, DataW'(sx));
    write_reg(RegSizeZ, DataW'(sz));
    write_reg(RegMirror, DataW'(mir));
    write_reg(RegRot, DataW'(rot));
    write_reg(RegOriginX, DataW'(ox));
    write_reg(RegOriginY, DataW'(oy));
    write_reg(RegOriginZ, DataW'(oz));
    settings++;
  endtask

  // Wait for every voxel to be taken and every box to come back, then let the
  // pipeline drain before touching the registers again.
  task automatic settle();
    while (accepted != pushed || expected_boxes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic queue_voxel(input voxel_t v);
    pending_voxels.push_back(v);
    pushed++;
    if (v.skip) skipped++;
    else counted++;
  endtask

  // Local voxel; the world fields carry garbage the block must ignore.
  function automatic voxel_t local_voxel(input logic [LocW-1:0] x, input logic [LocW-1:0] y,
                                         input logic [LocW-1:0] z, input logic skip,
                                         input logic last);
    voxel_t v;
    v = {1'b0, x, y, z, OrgW'($urandom), OrgW'($urandom), OrgW'($urandom), skip, last};
    return v;
  endfunction

  // Override voxel; the local fields carry garbage the block must ignore.
  function automatic voxel_t override_voxel(input logic signed [OrgW-1:0] x,
                                            input logic signed [OrgW-1:0] y,
                                            input logic signed [OrgW-1:0] z,
                                            input logic skip, input logic last);
    voxel_t v;
    v = {1'b1, LocW'($urandom), LocW'($urandom), LocW'($urandom), x, y, z, skip, last};
    return v;
  endfunction

  function automatic logic [LocW-1:0] rand_loc();
    case ($urandom_range(7))
      0: return '0;
      1: return LocMax;
      default: return LocW'($urandom);
    endcase
  endfunction

  function automatic logic signed [OrgW-1:0] rand_org();
    case ($urandom_range(9))
      0: return OrgMin;
      1: return OrgMax;
      2: return OrgW'($urandom_range(64)) - OrgW'(32);
      default: return OrgW'($urandom);
    endcase
  endfunction

  // Mostly legal extents, with zero and oversized codes mixed in.
  function automatic logic [SizeW-1:0] rand_size();
    case ($urandom_range(9))
      0: return '0;
      1: return SizeW'($urandom_range(SizeTop, MaxDim + 1));
      2: return SizeW'(MaxDim);
      3: return SizeW'(1);
      default: return SizeW'($urandom_range(MaxDim, 1));
    endcase
  endfunction

  // One run of 1..12 voxels closed by last; now and then every voxel skipped.
  task automatic queue_run();
    int len;
    bit hollow;
    logic skip;
    logic last;
    len = $urandom_range(12, 1);
    hollow = ($urandom_range(9) == 0);
    for (int i = 0; i < len; i++) begin
      skip = hollow || ($urandom_range(4) == 0);
      last = (i == len - 1);
      if ($urandom_range(1))
        queue_voxel(override_voxel(rand_org(), rand_org(), rand_org(), skip, last));
      else
        queue_voxel(local_voxel(rand_loc(), rand_loc(), rand_loc(), skip, last));
    end
  endtask

  initial begin
    int phase_start;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    item_kind_i = 1'b0;
    local_x_i   = '0;
    local_y_i   = '0;
    local_z_i   = '0;
    world_x_i   = '0;
    world_y_i   = '0;
    world_z_i   = '0;
    skip_i      = 1'b0;
    last_i      = 1'b0;
    out_ready_i = 1'b0;
    steady      = 1'b0;
    // Reset values of the placement registers.
    size_x_q = SizeW'(1);
    size_z_q = SizeW'(1);
    mirror_q = MirrorNone;
    rot_q    = RotNone;
    org_x_q  = '0;
    org_y_q  = '0;
    org_z_q  = '0;
    run_any  = 1'b0;
    run_box  = '0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset placement, an empty run, then extremes of every field,
    // an override mixed into a local run, and a skipped last after counted voxels.
    queue_voxel(local_voxel('0, '0, '0, 1'b1, 1'b1));
    queue_voxel(local_voxel(LocMax, LocMax, LocMax, 1'b0, 1'b0));
    queue_voxel(override_voxel(OrgMin, OrgMax, OrgMin, 1'b0, 1'b0));
    queue_voxel(local_voxel('0, '0, '0, 1'b1, 1'b1));
    settle();

    // Oversized and zero extents, spare mirror code, most negative origin.
    place(SizeTop, '0, MirrorSpare, RotCw90, OrgMin, OrgMax, '0);
    queue_voxel(local_voxel('0, '0, '0, 1'b0, 1'b0));
    queue_voxel(local_voxel(LocMax, LocMax, LocMax, 1'b0, 1'b0));
    queue_voxel(override_voxel(OrgMax, OrgMin, OrgMax, 1'b0, 1'b0));
    queue_voxel(local_voxel(LocW'(1234), LocW'(77), LocW'(3000), 1'b0, 1'b1));
    settle();

    place(SizeW'(MaxDim), SizeW'(MaxDim), MirrorX, Rot180, OrgMax, OrgMax, OrgMax);
    queue_voxel(local_voxel('0, '0, '0, 1'b0, 1'b0));
    queue_voxel(local_voxel(LocMax, LocMax, LocMax, 1'b0, 1'b1));
    queue_voxel(local_voxel(LocMax, '0, LocMax, 1'b0, 1'b1));
    settle();

    place(SizeW'(1), SizeTop, MirrorZ, RotCcw90, OrgMin, OrgMin, OrgMin);
    queue_voxel(local_voxel(LocMax, '0, '0, 1'b0, 1'b0));
    queue_voxel(local_voxel('0, LocMax, LocMax, 1'b0, 1'b1));
    queue_voxel(override_voxel(OrgMax, OrgMax, OrgMax, 1'b1, 1'b1));
    settle();

    // Random: each setting sweeps one mirror/rotation pair in turn, then a
    // batch of runs; two settings in the middle run with no idling at all.
    for (int phase = 0; pushed < VoxelTarget; phase++) begin
      steady = (phase == 4 || phase == 5);
      place(rand_size(), rand_size(), 2'(phase % 4), 2'((phase / 4) % 4),
            rand_org(), rand_org(), rand_org());
      phase_start = pushed;
      while (pushed - phase_start < VoxelsPerSetting) queue_run();
      settle();
    end
    steady = 1'b0;
    settle();

    $display("Closed %0d runs (%0d boxes seen) from %0d voxels counted and %0d skipped,",
             runs_closed, boxes_seen, counted, skipped);
    $display("over %0d placement settings with every mirror and rotation pair.", settings);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
